/* hdl/ldws_pkg.sv */
package ldws_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CODE_CFG_W = 12;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TS_W       = 64;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_DIP_THRESHOLD   = 2'd0;
    localparam cfg_idx_t CFG_HYSTERESIS      = 2'd1;
    localparam cfg_idx_t CFG_SMOOTHING_SHIFT = 2'd2;

    localparam logic [CODE_CFG_W-1:0] DIP_THRESHOLD_RST   = 12'd228;
    localparam logic [CODE_CFG_W-1:0] HYSTERESIS_RST      = 12'd68;
    localparam logic [SHIFT_W-1:0]    SMOOTHING_SHIFT_RST = 5'd10;
    localparam logic [SHIFT_W-1:0]    SHIFT_MIN           = 5'd1;
    localparam logic [SHIFT_W-1:0]    SHIFT_MAX           = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMP_A,
        ST_SAMP_B,
        ST_SAMP_C,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* hdl/ldws_item_if.sv */
interface ldws_item_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample_code;
    logic [63:0]            time_stamp;

    modport source (output valid, input ready, output command, output sample_code,
                    output time_stamp);
    modport sink   (input valid, output ready, input command, input sample_code,
                    input time_stamp);
endinterface

/* hdl/ldws_result_if.sv */
interface ldws_result_if #(
    parameter int SAMPLE_BITS   = 12,
    parameter int COUNT_BITS    = 16,
    parameter int INTERVAL_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic [SAMPLE_BITS-1:0]   min_code;
    logic [SAMPLE_BITS-1:0]   max_code;
    logic [SAMPLE_BITS-1:0]   baseline_code;
    logic [INTERVAL_BITS-1:0] min_interval;
    logic [INTERVAL_BITS-1:0] max_interval;
    logic [INTERVAL_BITS-1:0] avg_interval;
    logic [COUNT_BITS-1:0]    dip_count;
    logic [COUNT_BITS-1:0]    sample_count;

    modport source (output valid, input ready, output min_code, output max_code,
                    output baseline_code, output min_interval, output max_interval,
                    output avg_interval, output dip_count, output sample_count);
    modport sink   (input valid, output ready, input min_code, input max_code,
                    input baseline_code, input min_interval, input max_interval,
                    input avg_interval, input dip_count, input sample_count);
endinterface

/* hdl/ldws_div.sv */
module ldws_div
    import ldws_pkg::*;
#(
    parameter int DVD_W = 48,
    parameter int DVS_W = 16
)(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start && !busy_reg)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

/* hdl/light_dip_window_stats_unit.sv */
// Channel  Dir  Payload                                           Accepted when
// item     in   command, sample_code, time_stamp                  valid && ready
// result   out  min/max/baseline code, min/max/avg interval,      valid && ready
//               dip_count, sample_count
// cfg      in   cfg_index, cfg_data                               cfg_we
//
// A sample goes through accept, then interval/baseline difference, baseline step
// and window stats, then dip compare. A report runs the bit-serial divider for
// the average interval, skipped if the window is empty, then loads the output. A
// finished report waits in the output register while samples go on;
// a second report stalls until it is taken. Reset is immediate, no clearing pass.
module light_dip_window_stats_unit
    import ldws_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int COUNT_BITS    = 16,
    parameter int INTERVAL_BITS = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ldws_item_if.sink             item,
    ldws_result_if.source         result
);
    localparam int BASE_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_BITS = (INTERVAL_BITS + COUNT_BITS > 64) ? 64
                              : INTERVAL_BITS + COUNT_BITS;
    localparam int CMP_W    = ((SAMPLE_BITS > CODE_CFG_W) ? SAMPLE_BITS : CODE_CFG_W) + 1;

    state_t state_reg, state_next;

    logic [CODE_CFG_W-1:0]    thr_reg;
    logic [CODE_CFG_W-1:0]    hyst_reg;
    logic [SHIFT_W-1:0]       shift_reg;

    logic [SAMPLE_BITS-1:0]   code_reg;
    logic [TS_W-1:0]          ts_reg;
    logic [BASE_W-1:0]        diff_reg;
    logic                     up_reg;
    logic [INTERVAL_BITS-1:0] iv_reg;

    logic [BASE_W-1:0]        base_reg;
    logic                     have_reg;
    logic                     dipped_reg;
    logic [SAMPLE_BITS-1:0]   dip_level_reg;
    logic [TS_W-1:0]          prev_time_reg;
    logic [SAMPLE_BITS-1:0]   win_min_reg;
    logic [SAMPLE_BITS-1:0]   win_max_reg;
    logic [INTERVAL_BITS-1:0] iv_min_reg;
    logic [INTERVAL_BITS-1:0] iv_max_reg;
    logic [SUM_BITS-1:0]      iv_sum_reg;
    logic [COUNT_BITS-1:0]    dips_reg;
    logic [COUNT_BITS-1:0]    samples_reg;
    logic [INTERVAL_BITS-1:0] avg_reg;

    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   out_min_code_reg;
    logic [SAMPLE_BITS-1:0]   out_max_code_reg;
    logic [SAMPLE_BITS-1:0]   out_base_code_reg;
    logic [INTERVAL_BITS-1:0] out_min_iv_reg;
    logic [INTERVAL_BITS-1:0] out_max_iv_reg;
    logic [INTERVAL_BITS-1:0] out_avg_iv_reg;
    logic [COUNT_BITS-1:0]    out_dips_reg;
    logic [COUNT_BITS-1:0]    out_samples_reg;

    logic                     in_acc;
    logic                     win_empty;
    logic                     out_load;
    logic                     div_fail;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;
    logic [SUM_BITS-1:0]      div_quot;

    logic [SHIFT_W-1:0]       sh;
    logic [BASE_W-1:0]        fx;
    logic [BASE_W-1:0]        step;
    logic [TS_W-1:0]          ts_delta;
    logic [INTERVAL_BITS-1:0] iv_sat;
    logic [SUM_BITS:0]        sum_ext;
    logic [CMP_W-1:0]         b_ext;
    logic [CMP_W-1:0]         thr_ext;
    logic [CMP_W-1:0]         code_ext;
    logic [CMP_W-1:0]         lvl_hi;
    logic [CMP_W-1:0]         dip_at;

    assign in_acc    = item.valid && item.ready;
    assign win_empty = (samples_reg == '0);
    assign out_load  = (state_reg == ST_LOAD) && (!out_valid_reg || result.ready);
    assign div_fail  = |div_quot[SUM_BITS-1:INTERVAL_BITS];

    always_comb
    begin
        if (shift_reg < SHIFT_MIN)
            sh = SHIFT_MIN;
        else if (shift_reg > SHIFT_MAX)
            sh = SHIFT_MAX;
        else
            sh = shift_reg;

        fx       = {code_reg, {FRAC_BITS{1'b0}}};
        step     = diff_reg >> sh;
        ts_delta = ts_reg - prev_time_reg;
        iv_sat   = (|ts_delta[TS_W-1:INTERVAL_BITS]) ? '1 : ts_delta[INTERVAL_BITS-1:0];
        sum_ext  = {1'b0, iv_sum_reg} + (SUM_BITS + 1)'(iv_reg);

        b_ext    = CMP_W'(base_reg[BASE_W-1:FRAC_BITS]);
        thr_ext  = CMP_W'(thr_reg);
        code_ext = CMP_W'(code_reg);
        lvl_hi   = CMP_W'(dip_level_reg) + CMP_W'(hyst_reg);
        dip_at   = b_ext - thr_ext;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (item.command == CMD_SAMPLE)
                        state_next = ST_SAMP_A;
                    else if (win_empty)
                        state_next = ST_LOAD;
                    else
                    begin
                        div_ctrl.start = 1'b1;
                        state_next     = ST_DIV;
                    end
                end
            end
            ST_SAMP_A: state_next = ST_SAMP_B;
            ST_SAMP_B: state_next = ST_SAMP_C;
            ST_SAMP_C: state_next = ST_IDLE;
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= DIP_THRESHOLD_RST;
            hyst_reg  <= HYSTERESIS_RST;
            shift_reg <= SMOOTHING_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIP_THRESHOLD:   thr_reg   <= cfg_data[CODE_CFG_W-1:0];
                CFG_HYSTERESIS:      hyst_reg  <= cfg_data[CODE_CFG_W-1:0];
                CFG_SMOOTHING_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // state carried across windows, plus window statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            have_reg      <= 1'b0;
            dipped_reg    <= 1'b0;
            dip_level_reg <= '0;
            prev_time_reg <= '0;
            win_min_reg   <= '1;
            win_max_reg   <= '0;
            iv_min_reg    <= '1;
            iv_max_reg    <= '0;
            iv_sum_reg    <= '0;
            dips_reg      <= '0;
            samples_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_SAMP_A:
                begin
                    prev_time_reg <= ts_reg;
                    if (!have_reg)
                    begin
                        base_reg <= fx;
                        have_reg <= 1'b1;
                    end
                end
                ST_SAMP_B:
                begin
                    base_reg <= up_reg ? base_reg + step : base_reg - step;
                    if (code_reg < win_min_reg)
                        win_min_reg <= code_reg;
                    if (code_reg > win_max_reg)
                        win_max_reg <= code_reg;
                    if (iv_reg < iv_min_reg)
                        iv_min_reg <= iv_reg;
                    if (iv_reg > iv_max_reg)
                        iv_max_reg <= iv_reg;
                    iv_sum_reg <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
                    if (samples_reg != '1)
                        samples_reg <= samples_reg + 1'b1;
                end
                ST_SAMP_C:
                begin
                    if (dipped_reg)
                    begin
                        if (code_ext > lvl_hi)
                            dipped_reg <= 1'b0;
                    end
                    else if (b_ext >= thr_ext && code_ext < dip_at)
                    begin
                        dip_level_reg <= dip_at[SAMPLE_BITS-1:0];
                        dipped_reg    <= 1'b1;
                        if (dips_reg != '1)
                            dips_reg <= dips_reg + 1'b1;
                    end
                end
                ST_LOAD:
                begin
                    if (out_load)
                    begin
                        win_min_reg <= '1;
                        win_max_reg <= '0;
                        iv_min_reg  <= '1;
                        iv_max_reg  <= '0;
                        iv_sum_reg  <= '0;
                        dips_reg    <= '0;
                        samples_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            code_reg <= item.sample_code;
            ts_reg   <= item.time_stamp;
            avg_reg  <= '0;
        end
        if (state_reg == ST_SAMP_A)
        begin
            if (!have_reg)
            begin
                // first sample: baseline loads, interval is zero
                diff_reg <= '0;
                up_reg   <= 1'b1;
                iv_reg   <= '0;
            end
            else
            begin
                up_reg   <= (fx >= base_reg);
                diff_reg <= (fx >= base_reg) ? fx - base_reg : base_reg - fx;
                iv_reg   <= iv_sat;
            end
        end
        if (state_reg == ST_DIV && div_stat.done)
            avg_reg <= div_fail ? '1 : div_quot[INTERVAL_BITS-1:0];
    end

    ldws_div #(
        .DVD_W (SUM_BITS),
        .DVS_W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (iv_sum_reg),
        .divisor  (samples_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_min_code_reg  <= win_empty ? '0 : win_min_reg;
            out_max_code_reg  <= win_empty ? '0 : win_max_reg;
            out_base_code_reg <= base_reg[BASE_W-1:FRAC_BITS];
            out_min_iv_reg    <= win_empty ? '0 : iv_min_reg;
            out_max_iv_reg    <= win_empty ? '0 : iv_max_reg;
            out_avg_iv_reg    <= avg_reg;
            out_dips_reg      <= dips_reg;
            out_samples_reg   <= samples_reg;
        end
    end

    assign item.ready           = (state_reg == ST_IDLE) && !div_stat.busy;
    assign result.valid         = out_valid_reg;
    assign result.min_code      = out_min_code_reg;
    assign result.max_code      = out_max_code_reg;
    assign result.baseline_code = out_base_code_reg;
    assign result.min_interval  = out_min_iv_reg;
    assign result.max_interval  = out_max_iv_reg;
    assign result.avg_interval  = out_avg_iv_reg;
    assign result.dip_count     = out_dips_reg;
    assign result.sample_count  = out_samples_reg;

endmodule

/* hdl/ldws_chk.sv */
module ldws_chk
    import ldws_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int COUNT_BITS    = 16,
    parameter int INTERVAL_BITS = 32
)(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     in_command,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [SAMPLE_BITS-1:0]   min_code,
    input logic [SAMPLE_BITS-1:0]   max_code,
    input logic [INTERVAL_BITS-1:0] min_interval,
    input logic [INTERVAL_BITS-1:0] max_interval,
    input logic [INTERVAL_BITS-1:0] avg_interval,
    input logic [COUNT_BITS-1:0]    sample_count
);
    logic in_acc;
    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_command == CMD_SAMPLE |=> !in_ready)
        else $error("new request taken during sample update");

    a_report_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_command == CMD_REPORT |=> !$rose(out_valid))
        else $error("report produced too early");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_count != '0 |->
            min_code <= max_code && min_interval <= max_interval)
        else $error("window minimum above maximum");

    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_count == '0 |->
            min_code == '0 && max_code == '0 && avg_interval == '0)
        else $error("empty window report not zeroed");

endmodule

bind light_dip_window_stats_unit ldws_chk #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
) u_ldws_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .in_command   (item.command),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .min_code     (result.min_code),
    .max_code     (result.max_code),
    .min_interval (result.min_interval),
    .max_interval (result.max_interval),
    .avg_interval (result.avg_interval),
    .sample_count (result.sample_count)
);

/* tb/light_dip_window_stats_unit_tb.sv */
`timescale 1ns / 1ps

module light_dip_window_stats_unit_tb;
    import ldws_pkg::*;

    localparam int   QUIET_CYCLES = 16;
    localparam int   DRAIN_LIMIT  = 5000;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [11:0] min_code;
        logic [11:0] max_code;
        logic [11:0] baseline_code;
        logic [31:0] min_interval;
        logic [31:0] max_interval;
        logic [31:0] avg_interval;
        logic [15:0] dip_count;
        logic [15:0] sample_count;
    } report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ldws_item_if   item_ch ();
    ldws_result_if res_ch ();

    light_dip_window_stats_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (res_ch)
    );

    // detector copy: settings
    logic [11:0] thr_reg   = DIP_THRESHOLD_RST;
    logic [11:0] hys_reg   = HYSTERESIS_RST;
    logic [4:0]  shift_reg = SMOOTHING_SHIFT_RST;

    // detector copy: state
    logic [27:0] ema          = '0;
    bit          ema_valid    = 1'b0;
    bit          in_dip       = 1'b0;
    logic [11:0] dip_floor    = '0;
    logic [63:0] last_ts      = '0;
    logic [11:0] win_lo       = '1;
    logic [11:0] win_hi       = '0;
    logic [31:0] gap_lo       = '1;
    logic [31:0] gap_hi       = '0;
    logic [47:0] gap_sum      = '0;
    logic [15:0] dip_tally    = '0;
    logic [15:0] sample_tally = '0;

    report_t     pending_reports[$];
    int          bad_results     = 0;
    int          reports_checked = 0;
    int          requests_sent   = 0;
    int          cycle_count     = 0;
    int          hold_left       = 0;
    int          stall_left      = 0;
    bit          idle_on         = 1'b1;
    logic [63:0] now_ns          = '0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void fold_sample(input logic [11:0] code, input logic [63:0] ts);
        logic [27:0] fx;
        int          sh;
        logic [11:0] level;
        logic [63:0] delta;
        logic [31:0] gap;
        logic [48:0] wide_sum;
        fx = {code, 16'h0000};
        sh = int'(shift_reg);
        if (sh < 1)
            sh = 1;
        if (sh > 16)
            sh = 16;
        if (!ema_valid)
        begin
            ema       = fx;
            last_ts   = ts;
            ema_valid = 1'b1;
        end
        else if (fx >= ema)
            ema = ema + ((fx - ema) >> sh);
        else
            ema = ema - ((ema - fx) >> sh);
        level = ema[27:16];

        if (code < win_lo)
            win_lo = code;
        if (code > win_hi)
            win_hi = code;

        // wraps modulo 2^64, so a backward step saturates
        delta   = ts - last_ts;
        gap     = (delta > 64'h0000_0000_FFFF_FFFF) ? '1 : delta[31:0];
        last_ts = ts;
        if (gap < gap_lo)
            gap_lo = gap;
        if (gap > gap_hi)
            gap_hi = gap;
        wide_sum = {1'b0, gap_sum} + 49'(gap);
        gap_sum  = wide_sum[48] ? '1 : wide_sum[47:0];

        if (in_dip)
        begin
            if (int'(code) > int'(dip_floor) + int'(hys_reg))
                in_dip = 1'b0;
        end
        else if (level >= thr_reg && code < level - thr_reg)
        begin
            dip_floor = level - thr_reg;
            in_dip    = 1'b1;
            if (dip_tally != '1)
                dip_tally++;
        end

        if (sample_tally != '1)
            sample_tally++;
    endfunction

    function automatic void close_window();
        report_t     r;
        bit          empty;
        logic [47:0] avg_full;
        empty    = (sample_tally == 0);
        avg_full = empty ? '0 : gap_sum / sample_tally;
        r.min_code      = empty ? '0 : win_lo;
        r.max_code      = empty ? '0 : win_hi;
        r.baseline_code = ema[27:16];
        r.min_interval  = empty ? '0 : gap_lo;
        r.max_interval  = empty ? '0 : gap_hi;
        r.avg_interval  = (avg_full > 48'h0000_FFFF_FFFF) ? '1 : avg_full[31:0];
        r.dip_count     = dip_tally;
        r.sample_count  = sample_tally;
        pending_reports.push_back(r);
        win_lo       = '1;
        win_hi       = '0;
        gap_lo       = '1;
        gap_hi       = '0;
        gap_sum      = '0;
        dip_tally    = '0;
        sample_tally = '0;
    endfunction

    // result side: random stall bursts plus the long hold-off
    initial begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 17);
            res_ch.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    initial begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
        end
    end

    always @(posedge clk)
    begin : result_check
        report_t got;
        report_t want;
        string   bad;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.min_code      = res_ch.min_code;
            got.max_code      = res_ch.max_code;
            got.baseline_code = res_ch.baseline_code;
            got.min_interval  = res_ch.min_interval;
            got.max_interval  = res_ch.max_interval;
            got.avg_interval  = res_ch.avg_interval;
            got.dip_count     = res_ch.dip_count;
            got.sample_count  = res_ch.sample_count;
            if (pending_reports.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: report with none pending: %h", $realtime, got);
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                bad  = "";
                if (got.min_code !== want.min_code)
                    bad = {bad, " min_code"};
                if (got.max_code !== want.max_code)
                    bad = {bad, " max_code"};
                if (got.baseline_code !== want.baseline_code)
                    bad = {bad, " baseline_code"};
                if (got.min_interval !== want.min_interval)
                    bad = {bad, " min_interval"};
                if (got.max_interval !== want.max_interval)
                    bad = {bad, " max_interval"};
                if (got.avg_interval !== want.avg_interval)
                    bad = {bad, " avg_interval"};
                if (got.dip_count !== want.dip_count)
                    bad = {bad, " dip_count"};
                if (got.sample_count !== want.sample_count)
                    bad = {bad, " sample_count"};
                if (bad != "")
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: report %0d wrong:%s\n  exp %h\n  got %h",
                                 $realtime, reports_checked, bad, want, got);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [11:0] code, input logic [63:0] ts);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= cmd;
        item_ch.sample_code <= code;
        item_ch.time_stamp  <= ts;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        requests_sent++;
        if (cmd == CMD_REPORT)
            close_window();
        else
            fold_sample(code, ts);
    endtask

    // samples may still be in the pipe after the last report comes out
    task automatic wait_quiet();
        item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [11:0] thr, input logic [11:0] hys,
                                 input logic [11:0] shift_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIP_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        thr_reg = thr;
        cfg_index <= CFG_HYSTERESIS;
        cfg_data  <= hys;
        @(posedge clk);
        hys_reg = hys;
        cfg_index <= CFG_SMOOTHING_SHIFT;
        cfg_data  <= shift_word;
        @(posedge clk);
        shift_reg = shift_word[4:0];
        cfg_we <= 1'b0;
    endtask

    // light level toggling between lit and shadowed, with noise and odd timestamps
    task automatic run_scene(input int n_items);
        logic [11:0] bright;
        logic [11:0] dark;
        logic [63:0] step;
        bit          shadow;
        int          lvl;
        bright = 12'($urandom_range(600, 4095));
        lvl    = int'(bright) - int'(thr_reg) - int'($urandom_range(20, 500));
        dark   = (lvl < 0) ? 12'($urandom_range(0, 50)) : 12'(lvl);
        shadow = 1'b0;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(CMD_REPORT, 12'($urandom), {$urandom, $urandom});
            else if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    now_ns = {$urandom, $urandom};
                else
                    now_ns += 64'($urandom_range(0, 5000));
                send_item(CMD_SAMPLE, 12'($urandom), now_ns);
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    shadow = !shadow;
                lvl = int'(shadow ? dark : bright) + int'($urandom_range(0, 60)) - 30;
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 4095)
                    lvl = 4095;
                case ($urandom_range(0, 19))
                    0:       step = '0;
                    1:       step = {28'd0, 4'($urandom_range(1, 15)), $urandom};
                    default: step = 64'($urandom_range(100, 2000000));
                endcase
                now_ns += step;
                send_item(CMD_SAMPLE, 12'(lvl), now_ns);
            end
        end
    endtask

    task automatic test_first_sample_and_wrap();
        send_item(CMD_REPORT, 12'hFFF, '1);
        send_item(CMD_SAMPLE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFF0);
        send_item(CMD_SAMPLE, 12'd0, 64'd5);
        send_item(CMD_SAMPLE, 12'd3900, 64'd3);
        send_item(CMD_SAMPLE, 12'd3900, 64'd3);
        send_item(CMD_SAMPLE, 12'd4095, 64'd1003);
        send_item(CMD_SAMPLE, 12'd0, '1);
        send_item(CMD_SAMPLE, 12'd2048, 64'd0);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        send_item(CMD_REPORT, 12'hAAA, 64'h5555_5555_5555_5555);
        wait_quiet();
    endtask

    task automatic test_threshold_above_baseline();
        load_settings(12'd4095, 12'd4095, 12'd16);
        now_ns = 64'd1000;
        send_item(CMD_SAMPLE, 12'd0, now_ns);
        send_item(CMD_SAMPLE, 12'd4095, now_ns + 64'd10);
        send_item(CMD_SAMPLE, 12'd0, now_ns + 64'd20);
        send_item(CMD_SAMPLE, 12'd1, now_ns + 64'd4000);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        now_ns += 64'd4000;
        wait_quiet();
    endtask

    task automatic test_setting_extremes();
        load_settings(12'd0, 12'd0, 12'd1);
        run_scene(50);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        wait_quiet();
        load_settings(12'd4095, 12'd4095, 12'd16);
        run_scene(40);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        wait_quiet();
        // shift values outside 1..16 clamp
        load_settings(12'd150, 12'd40, 12'h0E0);
        run_scene(40);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        wait_quiet();
        load_settings(12'd300, 12'd100, 12'hFFF);
        run_scene(40);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        wait_quiet();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 3; p++)
        begin
            load_settings(12'($urandom_range(0, 600)), 12'($urandom_range(0, 300)),
                          {7'($urandom), 5'($urandom_range(1, 16))});
            run_scene(30);
            send_item(CMD_REPORT, 12'd0, 64'd0);
            wait_quiet();
        end
    endtask

    // result side held off while requests keep coming: reports back up into the input
    task automatic test_output_hold_off();
        idle_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            now_ns += 64'($urandom_range(1, 100000));
            if (i % 6 == 5)
                send_item(CMD_REPORT, 12'd0, 64'd0);
            else
                send_item(CMD_SAMPLE, 12'($urandom), now_ns);
        end
        send_item(CMD_REPORT, 12'd0, 64'd0);
        idle_on = 1'b1;
        wait_quiet();
    endtask

    // after a settling run, long gaps: every interval of the next window saturates, samples swing full scale
    task automatic test_interval_saturation();
        idle_on = 1'b0;
        load_settings(12'd0, 12'd0, 12'd1);
        for (int i = 0; i < 12; i++)
        begin
            now_ns += 64'd1000;
            send_item(CMD_SAMPLE, 12'd2048, now_ns);
        end
        wait_quiet();
        load_settings(12'd0, 12'd0, 12'd16);
        send_item(CMD_REPORT, 12'd0, 64'd0);
        for (int i = 0; i < 16; i++)
        begin
            now_ns += 64'h0000_0002_0000_0000;
            send_item(CMD_SAMPLE, (i % 2 == 0) ? 12'd0 : 12'd4095, now_ns);
        end
        send_item(CMD_REPORT, 12'd0, 64'd0);
        wait_quiet();
        idle_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        load_settings(DIP_THRESHOLD_RST, HYSTERESIS_RST, 12'(SMOOTHING_SHIFT_RST));
        idle_on = 1'b0;
        run_scene(60);
        send_item(CMD_REPORT, 12'd0, 64'd0);
    endtask

    initial begin : main_seq
        int spare;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_DIP_THRESHOLD;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_SAMPLE;
        item_ch.sample_code = '0;
        item_ch.time_stamp  = '0;
        res_ch.ready        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample_and_wrap();
        test_threshold_above_baseline();
        test_setting_extremes();
        test_random_settings();
        test_output_hold_off();
        test_interval_saturation();
        test_steady_stream();

        item_ch.valid <= 1'b0;
        spare = 0;
        while (pending_reports.size() != 0 && spare < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spare++;
        end
        repeat (60) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            bad_results++;
            $display("%0d reports never arrived", pending_reports.size());
        end

        $display("Ran %0d requests, %0d reports checked, %0d bad", requests_sent,
                 reports_checked, bad_results);
        $display("Covered first sample, timestamp wrap, setting extremes, hold-off, saturation");
        if (bad_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
